@@ hdl/srps_pkg.sv @@
package srps_pkg;

   // default sizes of the store
   localparam int MAX_ROWS_DEF    = 64;
   localparam int MAX_COLS_DEF    = 64;
   localparam int MAX_ENTRIES_DEF = 256;

   // fixed field widths
   localparam int CMD_W    = 2;
   localparam int ROW_W    = 6;
   localparam int COL_W    = 6;
   localparam int DATA_W   = 64;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 8;
   localparam int CNT_W    = 7;
   localparam int CSR_IDX_W = 1;

   localparam logic [CNT_W-1:0] ROW_COUNT_RST = 7'd64;
   localparam logic [CNT_W-1:0] COL_COUNT_RST = 7'd64;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOOKUP   = 2'd0,
      CMD_ACTIVATE = 2'd1,
      CMD_WRITE    = 2'd2,
      CMD_READ_ROW = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_FOUND   = 3'd0,
      STS_CREATED = 3'd1,
      STS_ABSENT  = 3'd2,
      STS_FULL    = 3'd3,
      STS_RANGE   = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROW_COUNT = 1'd0,
      REG_COL_COUNT = 1'd1
   } csr_reg_type;

endpackage

@@ hdl/srps_if.sv @@
interface srps_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [srps_pkg::CMD_W-1:0]           cmd;
   logic [srps_pkg::ROW_W-1:0]           row;
   logic [srps_pkg::COL_W-1:0]           col;
   logic signed [srps_pkg::DATA_W-1:0]   wdata;

   modport source (output valid, output cmd, output row, output col, output wdata,
                   input ready);
   modport sink   (input valid, input cmd, input row, input col, input wdata,
                   output ready);
endinterface

interface srps_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [srps_pkg::STATUS_W-1:0]        status;
   logic [srps_pkg::SLOT_W-1:0]          slot;
   logic [srps_pkg::COL_W-1:0]           entry_col;
   logic signed [srps_pkg::DATA_W-1:0]   rdata;
   logic                                 last;

   modport source (output valid, output status, output slot, output entry_col,
                   output rdata, output last, input ready);
   modport sink   (input valid, input status, input slot, input entry_col,
                   input rdata, input last, output ready);
endinterface

interface srps_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [srps_pkg::CSR_IDX_W-1:0]       index;
   logic [srps_pkg::CNT_W-1:0]           wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ hdl/srps_ptr_ram.sv @@
module srps_ptr_ram #(
   parameter int DEPTH = 65,
   parameter int AW    = 7,
   parameter int W     = 9
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [W-1:0]  wdata,
   input  logic [AW-1:0] raddr,
   output logic [W-1:0]  q
);

   logic [W-1:0]     mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [W-1:0]     q_ff;
   logic             qv_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      q_ff <= mem[raddr];
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         qv_ff    <= 1'b0;
      end else begin
         if (we) begin
            valid_ff[waddr] <= 1'b1;
         end
         qv_ff <= valid_ff[raddr];
      end
   end

   assign q = qv_ff ? q_ff : '0;

endmodule

@@ hdl/srps_entry_ram.sv @@
module srps_entry_ram #(
   parameter int DEPTH = 256,
   parameter int AW    = 8,
   parameter int W     = 70
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [W-1:0]  wdata,
   input  logic [AW-1:0] raddr,
   output logic [W-1:0]  q
);

   logic [W-1:0] mem [DEPTH];
   logic [W-1:0] q_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      q_ff <= mem[raddr];
   end

   assign q = q_ff;

endmodule

@@ hdl/srps_ctrl.sv @@
module srps_ctrl #(
   parameter int MAX_ROWS    = srps_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS    = srps_pkg::MAX_COLS_DEF,
   parameter int MAX_ENTRIES = srps_pkg::MAX_ENTRIES_DEF,
   localparam int PW = $clog2(MAX_ENTRIES + 1),
   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   localparam int RW = $clog2(MAX_ROWS + 1),
   localparam int EW = srps_pkg::COL_W + srps_pkg::DATA_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [srps_pkg::CNT_W-1:0] row_count,
   input  logic [srps_pkg::CNT_W-1:0] col_count,
   srps_req_if.sink                   req_chan,
   srps_rsp_if.source                 rsp_chan,
   output logic                       ptr_we,
   output logic [RW-1:0]              ptr_waddr,
   output logic [PW-1:0]              ptr_wdata,
   output logic [RW-1:0]              ptr_raddr,
   input  logic [PW-1:0]              ptr_q,
   output logic                       ent_we,
   output logic [AW-1:0]              ent_waddr,
   output logic [EW-1:0]              ent_wdata,
   output logic [AW-1:0]              ent_raddr,
   input  logic [EW-1:0]              ent_q
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD_START,
      S_RD_END,
      S_SEARCH,
      S_SHIFT,
      S_INSERT,
      S_INC,
      S_ROW_EMIT,
      S_RESP
   } state_type;

   state_type                       state_ff, state_in;
   srps_pkg::cmd_type               cmd_ff, cmd_in;
   logic [srps_pkg::ROW_W-1:0]      row_ff, row_in;
   logic [srps_pkg::COL_W-1:0]      col_ff, col_in;
   logic [srps_pkg::DATA_W-1:0]     wdata_ff, wdata_in;
   logic [PW-1:0]                   p_ff, p_in;
   logic [RW-1:0]                   r_ff, r_in;
   logic [PW-1:0]                   start_ff, start_in;
   logic [PW-1:0]                   end_ff, end_in;
   logic [PW-1:0]                   total_ff, total_in;
   srps_pkg::status_type            status_ff, status_in;
   logic [srps_pkg::SLOT_W-1:0]     slot_ff, slot_in;
   logic [srps_pkg::COL_W-1:0]      ecol_ff, ecol_in;
   logic [srps_pkg::DATA_W-1:0]     rdata_ff, rdata_in;
   logic                            last_ff, last_in;

   logic [srps_pkg::COL_W-1:0]      ent_col_q;
   logic [srps_pkg::DATA_W-1:0]     ent_val_q;
   logic                            range_err;

   assign ent_col_q = ent_q[EW-1 -: srps_pkg::COL_W];
   assign ent_val_q = ent_q[srps_pkg::DATA_W-1:0];

   assign range_err =
      !((7'(req_chan.row) < row_count) && (32'(req_chan.row) < MAX_ROWS)) ||
      ((srps_pkg::cmd_type'(req_chan.cmd) != srps_pkg::CMD_READ_ROW) &&
       !((7'(req_chan.col) < col_count) && (32'(req_chan.col) < MAX_COLS)));

   always_comb begin
      logic [PW-1:0] end_v;

      state_in  = state_ff;
      cmd_in    = cmd_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      wdata_in  = wdata_ff;
      p_in      = p_ff;
      r_in      = r_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      total_in  = total_ff;
      status_in = status_ff;
      slot_in   = slot_ff;
      ecol_in   = ecol_ff;
      rdata_in  = rdata_ff;
      last_in   = last_ff;
      ptr_we    = 1'b0;
      ptr_waddr = r_ff;
      ptr_wdata = ptr_q + PW'(1);
      ent_we    = 1'b0;
      ent_waddr = p_ff[AW-1:0];
      ent_wdata = {col_ff, wdata_ff};
      end_v     = (ptr_q < total_ff) ? ptr_q : total_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in   = srps_pkg::cmd_type'(req_chan.cmd);
               row_in   = req_chan.row;
               col_in   = req_chan.col;
               wdata_in = req_chan.wdata;
               if (range_err) begin
                  status_in = srps_pkg::STS_RANGE;
                  slot_in   = '0;
                  ecol_in   = '0;
                  rdata_in  = '0;
                  last_in   = 1'b1;
                  state_in  = S_RESP;
               end else begin
                  r_in     = RW'(req_chan.row);
                  state_in = S_RD_START;
               end
            end
         end
         S_RD_START: begin
            start_in = ptr_q;
            r_in     = r_ff + RW'(1);
            state_in = S_RD_END;
         end
         S_RD_END: begin
            end_in = end_v;
            p_in   = start_ff;
            if (cmd_ff == srps_pkg::CMD_READ_ROW) begin
               if (start_ff >= end_v) begin
                  status_in = srps_pkg::STS_ABSENT;
                  slot_in   = '0;
                  ecol_in   = '0;
                  rdata_in  = '0;
                  last_in   = 1'b1;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_ROW_EMIT;
               end
            end else begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            // one compare per cycle; the read of the next slot is already in flight
            if ((p_ff < end_ff) && (ent_col_q == col_ff)) begin
               status_in = srps_pkg::STS_FOUND;
               slot_in   = srps_pkg::SLOT_W'(p_ff);
               ecol_in   = col_ff;
               rdata_in  = ent_val_q;
               last_in   = 1'b1;
               if (cmd_ff == srps_pkg::CMD_WRITE) begin
                  ent_we   = 1'b1;
                  rdata_in = wdata_ff;
               end
               state_in = S_RESP;
            end else if ((p_ff < end_ff) && (ent_col_q < col_ff)) begin
               p_in = p_ff + PW'(1);
            end else if (cmd_ff != srps_pkg::CMD_ACTIVATE) begin
               status_in = srps_pkg::STS_ABSENT;
               slot_in   = '0;
               ecol_in   = col_ff;
               rdata_in  = '0;
               last_in   = 1'b1;
               state_in  = S_RESP;
            end else if (total_ff >= PW'(MAX_ENTRIES)) begin
               status_in = srps_pkg::STS_FULL;
               slot_in   = '0;
               ecol_in   = col_ff;
               rdata_in  = '0;
               last_in   = 1'b1;
               state_in  = S_RESP;
            end else if (p_ff == total_ff) begin
               state_in = S_INSERT;
            end else begin
               // hold the insert position in start_ff, walk down from the top
               start_in = p_ff;
               p_in     = total_ff - PW'(1);
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            ent_we    = 1'b1;
            ent_waddr = AW'(p_ff + PW'(1));
            ent_wdata = ent_q;
            if (p_ff == start_ff) begin
               state_in = S_INSERT;
            end else begin
               p_in = p_ff - PW'(1);
            end
         end
         S_INSERT: begin
            ent_we    = 1'b1;
            ent_wdata = {col_ff, {srps_pkg::DATA_W{1'b0}}};
            r_in      = RW'(row_ff) + RW'(1);
            state_in  = S_INC;
         end
         S_INC: begin
            ptr_we = 1'b1;
            if (r_ff == RW'(MAX_ROWS)) begin
               total_in  = total_ff + PW'(1);
               status_in = srps_pkg::STS_CREATED;
               slot_in   = srps_pkg::SLOT_W'(p_ff);
               ecol_in   = col_ff;
               rdata_in  = '0;
               last_in   = 1'b1;
               state_in  = S_RESP;
            end else begin
               r_in = r_ff + RW'(1);
            end
         end
         S_ROW_EMIT: begin
            status_in = srps_pkg::STS_FOUND;
            slot_in   = srps_pkg::SLOT_W'(p_ff);
            ecol_in   = ent_col_q;
            rdata_in  = ent_val_q;
            last_in   = ((p_ff + PW'(1)) >= end_ff);
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (rsp_chan.ready) begin
               if (last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  p_in     = p_ff + PW'(1);
                  state_in = S_ROW_EMIT;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
      end
      cmd_ff    <= cmd_in;
      row_ff    <= row_in;
      col_ff    <= col_in;
      wdata_ff  <= wdata_in;
      p_ff      <= p_in;
      r_ff      <= r_in;
      start_ff  <= start_in;
      end_ff    <= end_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      ecol_ff   <= ecol_in;
      rdata_ff  <= rdata_in;
      last_ff   <= last_in;
   end

   // read addresses follow the next pointer so data lines up with the current one
   assign ptr_raddr = r_in;
   assign ent_raddr = p_in[AW-1:0];

   assign req_chan.ready     = (state_ff == S_IDLE);
   assign rsp_chan.valid     = (state_ff == S_RESP);
   assign rsp_chan.status    = status_ff;
   assign rsp_chan.slot      = slot_ff;
   assign rsp_chan.entry_col = ecol_ff;
   assign rsp_chan.rdata     = rdata_ff;
   assign rsp_chan.last      = last_ff;

endmodule

@@ hdl/sparse_row_pattern_store.sv @@
// Lookup and write read the row's start and end pointers, then compare the row's entries in column
// order until the column is found or passed. Out-of-range requests go straight to the response.
// Activate of a new column moves every later entry up one slot, writes the new entry with value zero,
// then increments each row pointer above the row (MAX_ROWS - row of them).
// Row read gives the row's entries in column order, each one after the previous one is accepted.
// Reset: synchronous; registers back to 64, store empty, pointer valid bits cleared at once.
module sparse_row_pattern_store #(
   parameter int MAX_ROWS    = srps_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS    = srps_pkg::MAX_COLS_DEF,
   parameter int MAX_ENTRIES = srps_pkg::MAX_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   srps_req_if.sink    req_chan,
   srps_rsp_if.source  rsp_chan,
   srps_csr_if.sink    csr_chan
);

   // pointer width covers 0..MAX_ENTRIES, row pointer index covers 0..MAX_ROWS
   localparam int PW = $clog2(MAX_ENTRIES + 1);
   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int RW = $clog2(MAX_ROWS + 1);
   localparam int EW = srps_pkg::COL_W + srps_pkg::DATA_W;

   logic [srps_pkg::CNT_W-1:0] row_count_ff;
   logic [srps_pkg::CNT_W-1:0] col_count_ff;

   logic          ptr_we;
   logic [RW-1:0] ptr_waddr;
   logic [PW-1:0] ptr_wdata;
   logic [RW-1:0] ptr_raddr;
   logic [PW-1:0] ptr_q;
   logic          ent_we;
   logic [AW-1:0] ent_waddr;
   logic [EW-1:0] ent_wdata;
   logic [AW-1:0] ent_raddr;
   logic [EW-1:0] ent_q;

   // configuration: always ready, writes to unknown indexes drop
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= srps_pkg::ROW_COUNT_RST;
         col_count_ff <= srps_pkg::COL_COUNT_RST;
      end else if (csr_chan.valid) begin
         case (srps_pkg::csr_reg_type'(csr_chan.index))
            srps_pkg::REG_ROW_COUNT: row_count_ff <= csr_chan.wdata;
            srps_pkg::REG_COL_COUNT: col_count_ff <= csr_chan.wdata;
            default: begin
            end
         endcase
      end
   end

   // sequencer: range check, row pointer fetch, column scan, shift, pointer sweep, row emit
   srps_ctrl #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLS    (MAX_COLS),
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .row_count (row_count_ff),
      .col_count (col_count_ff),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .ptr_we    (ptr_we),
      .ptr_waddr (ptr_waddr),
      .ptr_wdata (ptr_wdata),
      .ptr_raddr (ptr_raddr),
      .ptr_q     (ptr_q),
      .ent_we    (ent_we),
      .ent_waddr (ent_waddr),
      .ent_wdata (ent_wdata),
      .ent_raddr (ent_raddr),
      .ent_q     (ent_q)
   );

   // row start pointers, MAX_ROWS + 1 of them; unwritten ones read as zero
   srps_ptr_ram #(
      .DEPTH (MAX_ROWS + 1),
      .AW    (RW),
      .W     (PW)
   ) u_ptr_ram (
      .clock (clock),
      .reset (reset),
      .we    (ptr_we),
      .waddr (ptr_waddr),
      .wdata (ptr_wdata),
      .raddr (ptr_raddr),
      .q     (ptr_q)
   );

   // column and value word of every stored entry, kept row after row
   srps_entry_ram #(
      .DEPTH (MAX_ENTRIES),
      .AW    (AW),
      .W     (EW)
   ) u_entry_ram (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_waddr),
      .wdata (ent_wdata),
      .raddr (ent_raddr),
      .q     (ent_q)
   );

endmodule
